// ----- hdl/palblend_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package palblend_pkg;

   localparam logic [1:0] MODE_ALPHA     = 2'd0;
   localparam logic [1:0] MODE_ALPHA_OPA = 2'd1;
   localparam logic [1:0] MODE_OPA       = 2'd2;
   localparam logic [1:0] MODE_OPA_KEY   = 2'd3;

   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_OPACITY = 2'd1;
   localparam logic [1:0] CSR_KEY     = 2'd2;

   localparam logic       OP_PAL_WRITE = 1'b0;
   localparam logic       OP_BLEND     = 1'b1;

   localparam logic [31:0] PACK_MASK  = 32'h07E0_F81F;
   localparam logic [5:0]  FULL_SCALE = 6'd32;

   typedef struct packed {
      logic        skip;
      logic        last;
      logic        hit;
      logic [5:0]  k;
      logic [15:0] dest;
   } pix_ctl_type;

   function automatic logic [31:0] spread(input logic [15:0] c);
      return {c, c} & PACK_MASK;
   endfunction

   function automatic logic [5:0] sat32(input logic [7:0] v);
      return (v > 8'(FULL_SCALE)) ? FULL_SCALE : v[5:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/palblend_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module palblend_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [15:0]   wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic [15:0]        rdata
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/palblend_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module palblend_mix (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      s1_valid,
   input  wire palblend_pkg::pix_ctl_type s1_ctl,
   input  wire logic [15:0]               src_color,
   output logic                           adv,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [15:0]                    out_pixel,
   output logic                           out_written,
   output logic                           out_last
);

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_skip_ff;
   logic        s2_last_ff;
   logic [15:0] s2_dest_ff;
   logic [31:0] s2_d_ff, s2_d_in;
   logic [31:0] s2_prod_ff, s2_prod_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_pixel_ff, out_pixel_in;
   logic        out_written_ff;
   logic        out_last_ff;

   logic [31:0] s_spread;
   logic [31:0] diff;
   logic [31:0] sum;

   assign adv = !out_valid_ff || out_ready;

   // stage 2: spread and scale the difference
   always_comb begin
      s_spread   = palblend_pkg::spread(s1_ctl.hit ? src_color : 16'd0);
      s2_d_in    = palblend_pkg::spread(s1_ctl.dest);
      diff       = s_spread - s2_d_in;
      s2_prod_in = diff * {26'd0, s1_ctl.k};
      s2_valid_in = s1_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_skip_ff <= s1_ctl.skip;
         s2_last_ff <= s1_ctl.last;
         s2_dest_ff <= s1_ctl.dest;
         s2_d_ff    <= s2_d_in;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // stage 3: accumulate, mask, fold
   always_comb begin
      sum          = (s2_d_ff + {5'd0, s2_prod_ff[31:5]}) & palblend_pkg::PACK_MASK;
      out_pixel_in = s2_skip_ff ? s2_dest_ff : (sum[15:0] | sum[31:16]);
      out_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pixel_ff   <= out_pixel_in;
         out_written_ff <= !s2_skip_ff;
         out_last_ff    <= s2_last_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_pixel   = out_pixel_ff;
   assign out_written = out_written_ff;
   assign out_last    = out_last_ff;

endmodule

`default_nettype wire

// ----- hdl/palette_rgb565_alpha_blender.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata index/color/alpha/dest, tuser op, tlast eol
// rsp_      out  rsp_tvalid/rsp_tready  tdata pixel, tuser written, tlast eol
// csr_      in   csr_we                 csr_index, csr_wdata
//
// one request per clock while stages advance; results go through s1, s2, out registers
// palette lives in a one-port-write, one-port-read ram with registered read
// all stages advance together when the output register is empty or taken
// reset clears control and config only; palette contents undefined until written

module palette_rgb565_alpha_blender #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // color_index, palette_color, alpha, dest_pixel
   input  wire logic        req_tuser,  // operation
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // pixel_out
   output logic             rsp_tuser,  // written
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [1:0]  mode_ff;
   logic [5:0]  opacity_ff;
   logic [7:0]  key_ff;

   logic [7:0]  color_index;
   logic [15:0] palette_color;
   logic [7:0]  alpha;
   logic [15:0] dest_pixel;

   logic        adv;
   logic        accept;
   logic        idx_hit;
   logic [5:0]  a_sat;
   logic [5:0]  o_sat;
   logic [11:0] ao;

   logic                      s1_valid_ff, s1_valid_in;
   palblend_pkg::pix_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [15:0]               src_color;

   assign color_index   = req_tdata[7:0];
   assign palette_color = req_tdata[23:8];
   assign alpha         = req_tdata[31:24];
   assign dest_pixel    = req_tdata[47:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= palblend_pkg::MODE_ALPHA;
         opacity_ff <= palblend_pkg::FULL_SCALE;
         key_ff     <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            palblend_pkg::CSR_MODE:    mode_ff    <= csr_wdata[1:0];
            palblend_pkg::CSR_OPACITY: opacity_ff <= csr_wdata[5:0];
            palblend_pkg::CSR_KEY:     key_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign idx_hit    = {1'b0, color_index} < 9'(PALETTE_ENTRIES);

   palblend_ram #(
      .DEPTH (PALETTE_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (accept && (req_tuser == palblend_pkg::OP_PAL_WRITE) && idx_hit),
      .waddr (color_index[AW-1:0]),
      .wdata (palette_color),
      .re    (accept && (req_tuser == palblend_pkg::OP_BLEND)),
      .raddr (color_index[AW-1:0]),
      .rdata (src_color)
   );

   // factor and skip decode
   always_comb begin
      a_sat = palblend_pkg::sat32(alpha);
      o_sat = palblend_pkg::sat32({2'd0, opacity_ff});
      ao    = {6'd0, a_sat} * {6'd0, o_sat};
      s1_ctl_in.last = req_tlast;
      s1_ctl_in.hit  = idx_hit;
      s1_ctl_in.dest = dest_pixel;
      unique case (mode_ff)
         palblend_pkg::MODE_ALPHA: begin
            s1_ctl_in.k    = a_sat;
            s1_ctl_in.skip = (alpha == 8'd0);
         end
         palblend_pkg::MODE_ALPHA_OPA: begin
            s1_ctl_in.k    = ao[10:5];
            s1_ctl_in.skip = 1'b0;
         end
         palblend_pkg::MODE_OPA: begin
            s1_ctl_in.k    = o_sat;
            s1_ctl_in.skip = 1'b0;
         end
         default: begin
            s1_ctl_in.k    = o_sat;
            s1_ctl_in.skip = (color_index == key_ff);
         end
      endcase
      s1_valid_in = accept && (req_tuser == palblend_pkg::OP_BLEND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   palblend_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid_ff),
      .s1_ctl      (s1_ctl_ff),
      .src_color   (src_color),
      .adv         (adv),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pixel   (rsp_tdata),
      .out_written (rsp_tuser),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- hdl/palblend_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module palblend_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

endmodule

bind palette_rgb565_alpha_blender palblend_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- test/palette_blend_checker.sv -----
`timescale 1ns / 1ps

module palette_blend_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,  // color_index, palette_color, alpha, dest_pixel
   input  wire logic        req_tuser,  // operation
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,  // pixel_out
   input  wire logic        rsp_tuser,  // written
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   output int               fail_count,
   output int               expected_left
);

   typedef struct packed {
      logic [15:0] pixel;
      logic        written;
      logic        line_end;
   } pixel_result_type;

   logic [15:0]      palette_mem [256];
   logic [1:0]       mode_reg;
   logic [5:0]       opacity_reg;
   logic [7:0]       key_reg;
   pixel_result_type expected_q [$];

   function automatic logic [31:0] widen565(input logic [15:0] c);
      return (32'(c) | (32'(c) << 16)) & palblend_pkg::PACK_MASK;
   endfunction

   function automatic logic [5:0] clamp_scale(input logic [7:0] v);
      return (v > 8'(palblend_pkg::FULL_SCALE)) ? palblend_pkg::FULL_SCALE : v[5:0];
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [7:0] idx,
                                                      input logic [7:0] alpha,
                                                      input logic [15:0] dest,
                                                      input logic last);
      logic [5:0]       a;
      logic [5:0]       o;
      logic [11:0]      ao;
      logic [31:0]      k;
      logic [31:0]      s;
      logic [31:0]      d;
      logic [31:0]      prod;
      logic [31:0]      sum;
      logic             skip;
      pixel_result_type r;
      a = clamp_scale(alpha);
      o = clamp_scale({2'b00, opacity_reg});
      skip = 1'b0;
      k = '0;
      case (mode_reg)
         palblend_pkg::MODE_ALPHA: begin
            k = 32'(a);
            skip = (alpha == 8'd0);
         end
         palblend_pkg::MODE_ALPHA_OPA: begin
            ao = 12'(o) * 12'(a);
            k = 32'(ao >> 5);
         end
         palblend_pkg::MODE_OPA: k = 32'(o);
         palblend_pkg::MODE_OPA_KEY: begin
            k = 32'(o);
            skip = (idx == key_reg);
         end
         default: k = '0;
      endcase
      s = widen565(palette_mem[idx]);
      d = widen565(dest);
      prod = (s - d) * k;
      sum = (d + (prod >> 5)) & palblend_pkg::PACK_MASK;
      r.line_end = last;
      if (skip) begin
         r.pixel = dest;
         r.written = 1'b0;
      end else begin
         r.pixel = sum[15:0] | sum[31:16];
         r.written = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         mode_reg = palblend_pkg::MODE_ALPHA;
         opacity_reg = palblend_pkg::FULL_SCALE;
         key_reg = '0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result with no request pending: pixel_out %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel_out: expected %h, got %h", want.pixel, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.written) begin
                  $error("written: expected %b, got %b", want.written, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.line_end) begin
                  $error("line_end: expected %b, got %b", want.line_end, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == palblend_pkg::OP_PAL_WRITE)
               palette_mem[req_tdata[7:0]] = req_tdata[23:8];
            else
               expected_q.push_back(predict_pixel(req_tdata[7:0], req_tdata[31:24],
                                                  req_tdata[47:32], req_tlast));
         end
         if (csr_we) begin
            case (csr_index)
               palblend_pkg::CSR_MODE:    mode_reg = csr_wdata[1:0];
               palblend_pkg::CSR_OPACITY: opacity_reg = csr_wdata[5:0];
               palblend_pkg::CSR_KEY:     key_reg = csr_wdata;
               default:     ;
            endcase
         end
      end
      expected_left = expected_q.size();
   end

endmodule

// ----- test/palette_rgb565_alpha_blender_tb.sv -----
`timescale 1ns / 1ps

module palette_rgb565_alpha_blender_tb;

   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam int         IDLE_LIMIT  = 4000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         PHASES      = 8;
   localparam int         PHASE_ITEMS = 235;

   typedef struct packed {
      logic        op;
      logic [7:0]  idx;
      logic [15:0] color;
      logic [7:0]  alpha;
      logic [15:0] dest;
      logic        last;
   } pixel_req_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int          fail_count;
   int          expected_left;

   pixel_req_type req_q [$];
   pixel_req_type cur_req;
   int          gap_left = 0;
   int          pushed_count = 0;
   int          sent_count = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          stall_rsp = 1'b0;
   bit          pal_known [256];
   logic [7:0]  known_idx [$];
   logic [7:0]  cur_key = '0;
   logic [1:0]  cur_mode = palblend_pkg::MODE_ALPHA;

   palette_rgb565_alpha_blender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   palette_blend_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (req_tvalid && req_tready)
         sent_count++;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_q.size() > 0) begin
            cur_req = req_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {cur_req.dest, cur_req.alpha, cur_req.color, cur_req.idx};
            req_tuser <= cur_req.op;
            req_tlast <= cur_req.last;
            if (!calm && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   initial begin
      forever begin
         if (stall_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_request(input pixel_req_type r);
      req_q.push_back(r);
      pushed_count++;
      while (req_q.size() >= 4) @(posedge clock);
   endtask

   task automatic pal_write(input logic [7:0] idx, input logic [15:0] color);
      pixel_req_type r;
      r = '{op: palblend_pkg::OP_PAL_WRITE, idx: idx, color: color, alpha: 8'($urandom),
            dest: 16'($urandom), last: 1'($urandom)};
      if (!pal_known[idx]) begin
         pal_known[idx] = 1'b1;
         known_idx.push_back(idx);
      end
      queue_request(r);
   endtask

   task automatic blend(input logic [7:0] idx, input logic [7:0] alpha,
                        input logic [15:0] dest, input logic last);
      pixel_req_type r;
      r = '{op: palblend_pkg::OP_BLEND, idx: idx, color: 16'($urandom), alpha: alpha,
            dest: dest, last: last};
      queue_request(r);
   endtask

   function automatic bit all_done();
      return req_q.size() == 0 && sent_count == pushed_count && expected_left == 0;
   endfunction

   task automatic drain();
      do begin
         while (!all_done()) @(posedge clock);
         repeat (6) @(posedge clock);
      end while (!all_done());
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == palblend_pkg::CSR_KEY)
         cur_key = val;
      if (idx == palblend_pkg::CSR_MODE)
         cur_mode = val[1:0];
   endtask

   task automatic write_config(input logic [1:0] mode, input logic [5:0] opa,
                               input logic [7:0] key);
      drain();
      write_reg(palblend_pkg::CSR_MODE, 8'(mode));
      write_reg(palblend_pkg::CSR_OPACITY, 8'(opa));
      write_reg(palblend_pkg::CSR_KEY, key);
   endtask

   function automatic logic [7:0] pick_source();
      if (pal_known[cur_key] && $urandom_range(0, 4) == 0)
         return cur_key;
      return known_idx[$urandom_range(0, known_idx.size() - 1)];
   endfunction

   task automatic random_request();
      int          pick;
      logic [7:0]  alpha;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if ($urandom_range(0, 1) == 0)
            pal_write(8'($urandom_range(0, 63)), 16'($urandom));
         else
            pal_write(8'($urandom), 16'($urandom));
      end else begin
         if (pick < 30)
            alpha = 8'd0;
         else if (pick < 65)
            alpha = 8'($urandom_range(0, 40));
         else
            alpha = 8'($urandom);
         blend(pick_source(), alpha, 16'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      logic [5:0] opa;
      logic [7:0] key;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: palette extremes, every mode, skips and saturation
      pal_write(8'd0, 16'h0000);
      pal_write(8'd255, 16'hFFFF);
      pal_write(8'd1, 16'hF800);
      pal_write(8'd2, 16'h07E0);
      pal_write(8'd3, 16'h001F);
      blend(8'd255, 8'd0, 16'h1234, 1'b0);
      blend(8'd255, 8'd1, 16'h0000, 1'b0);
      blend(8'd0, 8'd32, 16'hFFFF, 1'b1);
      blend(8'd1, 8'd33, 16'h07E0, 1'b0);
      blend(8'd2, 8'd255, 16'hF81F, 1'b1);
      blend(8'd3, 8'd31, 16'hFFFF, 1'b0);
      write_config(palblend_pkg::MODE_ALPHA_OPA, 6'd63, 8'd0);
      blend(8'd1, 8'd255, 16'h001F, 1'b0);
      blend(8'd2, 8'd16, 16'h0000, 1'b1);
      blend(8'd255, 8'd0, 16'h8410, 1'b0);
      write_config(palblend_pkg::MODE_OPA, 6'd0, 8'd0);
      blend(8'd255, 8'd20, 16'hABCD, 1'b0);
      drain();
      write_reg(CSR_SPARE, 8'd255);
      write_config(palblend_pkg::MODE_OPA_KEY, 6'd20, 8'd2);
      blend(8'd2, 8'd7, 16'h5555, 1'b1);
      blend(8'd1, 8'd7, 16'hAAAA, 1'b0);
      blend(8'd0, 8'd0, 16'h7BEF, 1'b0);
      write_config(palblend_pkg::MODE_OPA_KEY, 6'd32, 8'd0);
      blend(8'd0, 8'd9, 16'h1111, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: opa = 6'd32;
            1: opa = 6'd0;
            2: opa = 6'd63;
            3: opa = 6'd33;
            4: opa = 6'd1;
            6: opa = 6'd31;
            default: opa = 6'($urandom);
         endcase
         if (p == 0)
            key = 8'd0;
         else if (p == 1)
            key = 8'd255;
         else
            key = 8'($urandom);
         write_config(2'(p % 4), opa, key);
         calm = (p == PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20)
               stall_rsp = 1'b1;
            if (p == 3 && i == PHASE_ITEMS / 2)
               drain();
            random_request();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/palblend_pkg.sv
hdl/palblend_ram.sv
hdl/palblend_mix.sv
hdl/palette_rgb565_alpha_blender.sv
hdl/palblend_chk.sv
test/palette_blend_checker.sv
test/palette_rgb565_alpha_blender_tb.sv
